// ===== sv/icfm_pkg.sv =====
// ----------------------------------------------------------------------------
// icfm_pkg
// shared types and constants for the input capture frequency meter
// ----------------------------------------------------------------------------
package icfm_pkg;

    // width of the capture timer
    localparam int CounterBits = 16;
    localparam logic [15:0] CntMask = 16'((32'd1 << CounterBits) - 32'd1);

    localparam int DivBits = 40;   // dividend and quotient width
    localparam int PerBits = 32;   // period (divisor) width
    localparam int QueueDepth = 2;

    localparam logic [15:0] ModuloReset = 16'hFFFF & CntMask;
    localparam logic [39:0] DividendReset = 40'd119304647;

    // configuration register indexes
    typedef enum logic
    {
        REG_MODULO   = 1'b0,
        REG_DIVIDEND = 1'b1
    } icfm_reg_t;

    // divider sequencer states, one-hot
    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } icfm_state_t;

    // job passed from the front end to the queue
    typedef struct packed
    {
        logic        valid;
        logic [31:0] period;
    } icfm_job_t;

    // queue status seen by both sides
    typedef struct packed
    {
        logic full;
        logic empty;
    } icfm_qstat_t;

endpackage

// ===== sv/input_capture_frequency_meter_unit.sv =====
// ----------------------------------------------------------------------------
// input_capture_frequency_meter_unit
// period and frequency meter driven by timer capture and overflow events
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one item per timer event report (overflow flag, edge flag,
//   captured count). overflows bump a wrapping 16-bit counter; edges pair up,
//   and the closing edge of each pair yields one result item on the m_* channel
//   carrying frequency_q8 = rate_dividend_q8 / period, the period and a
//   zero-period flag (frequency 0 when the period is zero).
//   cfg_* channel: always ready; index 0 writes the timer modulo, index 1
//   the 40-bit q8 dividend. write it only while the block is idle.
//   each pair's period passes the front stage register, the queue and the
//   40-step radix-2 divider in the back end (a zero period skips it) before m_tvalid rises.
//   the front end takes an item every cycle, except while a period waits
//   in its stage; the divider, one period at a time, sets the result rate.
//   a two-entry period queue lets the front keep taking items while the
//   divider works and while a finished result waits on m_tready.
//   reset: overflow counter and edge pairing cleared, registers back to
//   their defaults, queue empty, no result item pending.
//   stall: a held result keeps m_tdata stable; once the queue is full the
//   front deasserts s_tready after the next pairing edge.
// ----------------------------------------------------------------------------
module input_capture_frequency_meter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // overflow_seen, edge_seen, capture_value[15:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // frequency_q8[39:0], period_ticks[31:0], zero_period, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [39:0] cfg_data
);
    import icfm_pkg::*;

    logic [15:0] modulo_reg;
    logic [39:0] dividend_reg;
    icfm_job_t   push;
    icfm_qstat_t qstat;
    logic [31:0] head;
    logic        pop;
    logic [39:0] frequency_q8;
    logic [31:0] period_ticks;
    logic        zero_period;

    // configuration registers, always ready, written whenever cfg_valid is high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulo_reg <= ModuloReset;
            dividend_reg <= DividendReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODULO:   modulo_reg <= cfg_data[15:0] & CntMask;
                REG_DIVIDEND: dividend_reg <= cfg_data;
                default:      modulo_reg <= modulo_reg;
            endcase
        end
    end

    // front end: overflow counting, edge pairing, period forming
    icfm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .overflow_seen (s_tdata[0]),
        .edge_seen     (s_tdata[1]),
        .capture_value (s_tdata[17:2]),
        .modulo_value  (modulo_reg),
        .qstat         (qstat),
        .push          (push)
    );

    // periods waiting for the divider
    icfm_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    // back end: divider and result register
    icfm_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .qstat            (qstat),
        .head             (head),
        .pop              (pop),
        .rate_dividend_q8 (dividend_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .frequency_q8     (frequency_q8),
        .period_ticks     (period_ticks),
        .zero_period      (zero_period)
    );

    assign m_tdata = {7'd0, zero_period, period_ticks, frequency_q8};

endmodule

// ===== sv/icfm_front.sv =====
// ----------------------------------------------------------------------------
// icfm_front
// accepts items, counts overflows, pairs edges and forms the period
// ----------------------------------------------------------------------------
module icfm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                overflow_seen,
    input  logic                edge_seen,
    input  logic [15:0]         capture_value,
    input  logic [15:0]         modulo_value,
    input  icfm_pkg::icfm_qstat_t qstat,
    output icfm_pkg::icfm_job_t push
);
    import icfm_pkg::*;

    logic [15:0]        overflow_count_reg;
    logic [15:0]        overflow_count_next;
    logic               second_pending_reg;
    logic [15:0]        first_ovf_reg;
    logic [15:0]        first_cap_reg;
    logic               stage_valid_reg;
    logic signed [16:0] ovf_diff_reg;
    logic signed [16:0] cap_diff_reg;
    logic               accept;
    logic [15:0]        cap_masked;
    logic signed [33:0] product;

    assign in_ready = !stage_valid_reg;
    assign accept = in_valid && in_ready;
    assign cap_masked = capture_value & CntMask;
    assign overflow_count_next = overflow_count_reg + {15'd0, overflow_seen};

    // exact (ovf2 - ovf1) * modulo, kept modulo 2^32 below
    assign product = ovf_diff_reg * $signed({1'b0, modulo_value});

    assign push.valid = stage_valid_reg && !qstat.full;
    assign push.period = product[31:0] + {{15{cap_diff_reg[16]}}, cap_diff_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overflow_count_reg <= '0;
            second_pending_reg <= 1'b0;
            first_ovf_reg <= '0;
            first_cap_reg <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (push.valid)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                overflow_count_reg <= overflow_count_next;
                if (edge_seen)
                begin
                    if (!second_pending_reg)
                    begin
                        first_ovf_reg <= overflow_count_next;
                        first_cap_reg <= cap_masked;
                        second_pending_reg <= 1'b1;
                    end
                    else
                    begin
                        second_pending_reg <= 1'b0;
                        stage_valid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // signed differences of the paired edges
    always_ff @(posedge clk)
    begin
        if (accept && edge_seen && second_pending_reg)
        begin
            ovf_diff_reg <= $signed({1'b0, overflow_count_next}) - $signed({1'b0, first_ovf_reg});
            cap_diff_reg <= $signed({1'b0, cap_masked}) - $signed({1'b0, first_cap_reg});
        end
    end

endmodule

// ===== sv/icfm_queue.sv =====
// ----------------------------------------------------------------------------
// icfm_queue
// short period queue between the front end and the divider
// ----------------------------------------------------------------------------
module icfm_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  icfm_pkg::icfm_job_t   push,
    input  logic                  pop,
    output logic [31:0]           head,
    output icfm_pkg::icfm_qstat_t qstat
);
    import icfm_pkg::*;

    logic [31:0] mem_reg [QueueDepth];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign qstat.full = (count_reg == 2'(QueueDepth));
    assign qstat.empty = (count_reg == 2'd0);
    assign do_push = push.valid && !qstat.full;
    assign do_pop = pop && !qstat.empty;
    assign head = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/icfm_back.sv =====
// ----------------------------------------------------------------------------
// icfm_back
// radix-2 restoring divider and output register
// ----------------------------------------------------------------------------
module icfm_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  icfm_pkg::icfm_qstat_t qstat,
    input  logic [31:0]           head,
    output logic                  pop,
    input  logic [39:0]           rate_dividend_q8,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [39:0]           frequency_q8,
    output logic [31:0]           period_ticks,
    output logic                  zero_period
);
    import icfm_pkg::*;

    icfm_state_t state_reg;
    logic [5:0]  step_reg;
    logic [32:0] rem_reg;
    logic [39:0] quot_reg;
    logic [31:0] divisor_reg;
    logic        zero_reg;
    logic        out_valid_reg;
    logic [32:0] rem_shift;
    logic [32:0] rem_diff;
    logic        fits;
    logic        load_out;

    assign pop = (state_reg == ST_IDLE) && !qstat.empty;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // one quotient bit per cycle
    assign rem_shift = {rem_reg[31:0], quot_reg[DivBits-1]};
    assign rem_diff = rem_shift - {1'b0, divisor_reg};
    assign fits = !rem_diff[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces the one taken in the same cycle
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        step_reg <= '0;
                        state_reg <= (head == '0) ? ST_HOLD : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(DivBits - 1))
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            divisor_reg <= head;
            zero_reg <= (head == '0);
            rem_reg <= '0;
            quot_reg <= (head == '0) ? '0 : rate_dividend_q8;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= fits ? rem_diff : rem_shift;
            quot_reg <= {quot_reg[DivBits-2:0], fits};
        end
        if (load_out)
        begin
            frequency_q8 <= quot_reg;
            period_ticks <= divisor_reg;
            zero_period <= zero_reg;
        end
    end

endmodule

// ===== test/input_capture_frequency_meter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// input_capture_frequency_meter_unit_tb
// self-checking bench: event reports in, period and frequency results out
// ----------------------------------------------------------------------------
// a scoreboard object mirrors the overflow counter and the edge pairing,
// works out period, frequency and the zero-period flag of each pair's closing edge,
// and compares each result item with the oldest pending prediction. a short
// directed run comes first, then random traffic under several register
// settings and handshake pressure patterns.
// ----------------------------------------------------------------------------
module input_capture_frequency_meter_unit_tb;

    import icfm_pkg::*;

    // cycles to let pass after the last result before touching registers
    localparam int DrainCycles = 60;

    typedef struct packed
    {
        logic [39:0] frequency_q8;
        logic [31:0] period_ticks;
        logic        zero_period;
    } meter_result_t;

    class meter_scoreboard;
        logic [15:0]   modulo;
        logic [39:0]   dividend;
        logic [15:0]   ovf_count;
        bit            edge_pending;
        logic [15:0]   first_ovf;
        logic [15:0]   first_cap;
        meter_result_t result_q[$];
        int            errors;
        int            matched;

        function new();
            modulo = ModuloReset;
            dividend = DividendReset;
            ovf_count = '0;
            edge_pending = 1'b0;
            first_ovf = '0;
            first_cap = '0;
            errors = 0;
            matched = 0;
        endfunction

        function void write_reg(icfm_reg_t idx, logic [39:0] value);
            if (idx == REG_MODULO)
                modulo = value[15:0] & CntMask;
            else
                dividend = value;
        endfunction

        // update the mirrored state for one accepted event report
        function void note_input(bit ovf, bit edge_flag, logic [15:0] cap_in);
            logic [15:0]   cap;
            logic [31:0]   stamp_a;
            logic [31:0]   stamp_b;
            logic [63:0]   quot;
            meter_result_t res;
            cap = cap_in & CntMask;
            if (ovf)
                ovf_count = ovf_count + 16'd1;
            if (edge_flag)
            begin
                if (!edge_pending)
                begin
                    first_ovf = ovf_count;
                    first_cap = cap;
                    edge_pending = 1'b1;
                end
                else
                begin
                    edge_pending = 1'b0;
                    stamp_a = 32'(first_ovf) * 32'(modulo) + 32'(first_cap);
                    stamp_b = 32'(ovf_count) * 32'(modulo) + 32'(cap);
                    res.period_ticks = stamp_b - stamp_a;
                    if (res.period_ticks == 32'd0)
                    begin
                        res.frequency_q8 = '0;
                        res.zero_period = 1'b1;
                    end
                    else
                    begin
                        quot = {24'd0, dividend} / {32'd0, res.period_ticks};
                        res.frequency_q8 = quot[39:0];
                        res.zero_period = 1'b0;
                    end
                    result_q.push_back(res);
                end
            end
        endfunction

        function void check_result(logic [79:0] tdata);
            meter_result_t want;
            if (result_q.size() == 0)
            begin
                $display("%0t unexpected result item: expected none, actual %h",
                         $time, tdata[72:0]);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (tdata[39:0] !== want.frequency_q8)
                begin
                    $display("%0t frequency_q8: expected %h, actual %h",
                             $time, want.frequency_q8, tdata[39:0]);
                    errors++;
                end
                if (tdata[71:40] !== want.period_ticks)
                begin
                    $display("%0t period_ticks: expected %h, actual %h",
                             $time, want.period_ticks, tdata[71:40]);
                    errors++;
                end
                if (tdata[72] !== want.zero_period)
                begin
                    $display("%0t zero_period: expected %b, actual %b",
                             $time, want.zero_period, tdata[72]);
                    errors++;
                end
                matched++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // overflow_seen, edge_seen, capture_value[15:0], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // frequency_q8[39:0], period_ticks[31:0], zero_period, pad
    logic        cfg_valid;
    logic        cfg_ready;
    icfm_reg_t   cfg_index;
    logic [39:0] cfg_data;

    meter_scoreboard sb;

    int send_idle_pct;      // chance per item of a sender idle cycle
    int recv_stall_pct;     // chance per cycle of m_tready low
    int items_sent;
    int settings_used;

    input_capture_frequency_meter_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 time unit clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver back-pressure, one decision per cycle on the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every accepted result item goes straight to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // one event report; called on a falling edge, returns on a falling edge
    task automatic send_item(bit ovf, bit edge_flag, logic [15:0] cap);
        bit done;
        done = 1'b0;
        // random idle cycles ahead of the item
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, cap, edge_flag, ovf};
        while (!done)
        begin
            @(posedge clk);
            done = s_tready;
        end
        sb.note_input(ovf, edge_flag, cap);
        items_sent++;
        @(negedge clk);
    endtask

    // register write; only used while the block is idle
    task automatic write_reg(icfm_reg_t idx, logic [39:0] value);
        bit done;
        done = 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        while (!done)
        begin
            @(posedge clk);
            done = cfg_ready;
        end
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop sending, wait for all predicted results, then let the divider settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.result_q.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // random event report, biased toward edge pairs with random content
    task automatic random_item();
        bit          ovf;
        bit          edge_flag;
        logic [15:0] cap;
        int          pick;
        pick = $urandom_range(99);
        if (sb.edge_pending && pick < 8)
        begin
            // repeat the first capture: zero period unless overflows intervened under a nonzero modulo
            ovf = 1'b0;
            edge_flag = 1'b1;
            cap = sb.first_cap;
        end
        else
        begin
            ovf = ($urandom_range(99) < 30);
            edge_flag = ($urandom_range(99) < 55);
            pick = $urandom_range(99);
            if (pick < 10)
                cap = 16'h0000;
            else if (pick < 20)
                cap = 16'hFFFF;
            else
                cap = 16'($urandom);
        end
        send_item(ovf, edge_flag, cap);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, logic [15:0] modulo,
                             logic [39:0] dividend, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(REG_MODULO, {24'd0, modulo});
        write_reg(REG_DIVIDEND, dividend);
        settings_used++;
        repeat (count) random_item();
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODULO;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        settings_used = 1;
        sb = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part under the reset register values
        send_item(1'b0, 1'b0, 16'hFFFF);   // no edge, capture ignored
        send_item(1'b0, 1'b1, 16'h0000);   // first edge
        send_item(1'b0, 1'b1, 16'hFFFF);   // closing edge, full count
        send_item(1'b1, 1'b0, 16'h5A5A);   // overflow only
        send_item(1'b1, 1'b1, 16'h1234);   // overflow counted before the edge
        send_item(1'b0, 1'b1, 16'h1234);   // same stamp: zero period
        send_item(1'b0, 1'b1, 16'd100);
        send_item(1'b1, 1'b0, 16'h0000);
        send_item(1'b1, 1'b0, 16'hFFFF);
        send_item(1'b0, 1'b1, 16'd50);     // period across two overflows
        send_item(1'b0, 1'b1, 16'hFFFF);
        send_item(1'b0, 1'b1, 16'h0000);   // backward stamp wraps mod 2^32
        send_item(1'b1, 1'b1, 16'h0000);
        send_item(1'b1, 1'b1, 16'h0001);
        send_item(1'b0, 1'b0, 16'hA5C3);
        drain();

        // zero dividend with a tiny modulo
        run_phase(0, 0, 16'd1, 40'd0, 20);

        // random traffic over the pressure patterns and register extremes
        run_phase(0, 0, 16'hFFFF, 40'hFF_FFFF_FFFF, 400);
        run_phase(81, 0, 16'd0, 40'd1, 400);
        run_phase(0, 81, 16'($urandom), 40'({$urandom, $urandom}), 400);
        run_phase(28, 28, 16'd1, 40'd0, 130);
        run_phase(28, 28, 16'($urandom), 40'({$urandom, $urandom}), 550);

        $display("covered %0d event reports and %0d result items", items_sent, sb.matched);
        $display("over %0d register settings, zero periods and mixed back-pressure",
                 settings_used);
        if (sb.errors == 0 && sb.result_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/icfm_pkg.sv
sv/icfm_front.sv
sv/icfm_queue.sv
sv/icfm_back.sv
sv/input_capture_frequency_meter_unit.sv
test/input_capture_frequency_meter_unit_tb.sv
